// ===== design/scan_polar_to_cartesian_top_defines.svh =====
// Assertion macros shared by the scan converter. Each use stands on a line of its own,
// with no trailing semicolon.
`ifndef SCAN_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH
`define SCAN_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH
`ifndef SYNTH
// Property that is checked only outside reset.
`define SPC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("scan converter check failed");
// Property that is checked during reset as well.
`define SPC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("scan converter check failed");
`else
`define SPC_ASSERT(label, prop)
`define SPC_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== design/spc_pkg.sv =====
`default_nettype none
package spc_pkg;

   // Only the low RANGE_BITS bits of a range sample take part in the math.
   localparam int RANGE_BITS = 16;
   // Only the top ANGLE_BITS bits of the beam angle are kept.
   localparam int ANGLE_BITS = 32;

   localparam int RANGE_IN_W = 16;
   localparam int RANGE_W    = (RANGE_BITS < RANGE_IN_W) ? RANGE_BITS : RANGE_IN_W;
   localparam int INDEX_W    = 16;
   localparam int ANGLE_W    = 32;
   localparam int COORD_W    = 17;

   localparam logic [ANGLE_W-1:0] ANGLE_MASK = ~((ANGLE_W'(1) << (ANGLE_W - ANGLE_BITS))
                                                - ANGLE_W'(1));

   // CORDIC arithmetic.
   localparam int CORDIC_STEPS   = 30;
   localparam int KINV_W         = 30;
   localparam logic [KINV_W-1:0] KINV = KINV_W'(652032874);
   localparam int PRESCALE_SHIFT = 14;
   localparam int FRAC           = 16;
   localparam int PROD_W         = RANGE_W + KINV_W;
   localparam int X0_W           = PROD_W - PRESCALE_SHIFT;
   localparam int CW             = X0_W + 2;
   localparam int ZW             = 32;
   localparam int R_W            = CW - FRAC + 1;
   localparam int RSAT_W         = (R_W > COORD_W) ? R_W : COORD_W;
   localparam int COORD_MAX      = 65535;

   localparam logic [ZW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Queue depths.
   localparam int LINK_DEPTH = 4;
   localparam int LINK_PTR_W = $clog2(LINK_DEPTH);
   localparam int LINK_CNT_W = $clog2(LINK_DEPTH + 1);
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

   // Register map.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_ANGLE = 2'd0,
      CSR_ANGLE_STEP  = 2'd1,
      CSR_SCAN_LENGTH = 2'd2
   } csr_index_type;

   localparam logic [ANGLE_W-1:0] START_ANGLE_RESET = 32'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_STEP_RESET  = 32'd11930465;
   localparam logic [INDEX_W-1:0] SCAN_LENGTH_RESET = 16'd360;

   // Request passed from the front end to the rotation pipeline.
   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic [INDEX_W-1:0] sample_index;
      logic               last_point;
      logic [ANGLE_W-1:0] angle;
   } link_item_type;

   // Payload of one CORDIC pipeline stage.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [1:0]           quadrant;
      logic [INDEX_W-1:0]   sample_index;
      logic                 last_point;
   } cordic_type;

   // One finished point.
   typedef struct packed {
      logic signed [COORD_W-1:0] x_mm;
      logic signed [COORD_W-1:0] y_mm;
      logic [INDEX_W-1:0]        point_index;
      logic                      last_point;
   } point_type;

endpackage
`default_nettype wire

// ===== design/spc_front.sv =====
`default_nettype none
module spc_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic [spc_pkg::RANGE_IN_W-1:0]     req_range_mm,
   input  wire logic [spc_pkg::INDEX_W-1:0]        req_sample_index,
   input  wire logic [spc_pkg::ANGLE_W-1:0]        start_angle,
   input  wire logic [spc_pkg::ANGLE_W-1:0]        angle_step,
   input  wire logic [spc_pkg::INDEX_W-1:0]        scan_length,
   input  wire logic                               link_full,
   output logic                                    link_push,
   output spc_pkg::link_item_type                  link_item
);

   localparam int IW = spc_pkg::INDEX_W;
   localparam int AW = spc_pkg::ANGLE_W;

   logic                        accept;
   logic                        drop;
   logic [IW+AW-1:0]            step_prod;

   logic                        f1_valid_ff, f1_valid_in;
   logic [spc_pkg::RANGE_W-1:0] f1_range_ff, f1_range_in;
   logic [IW-1:0]               f1_index_ff, f1_index_in;
   logic                        f1_last_ff, f1_last_in;
   logic [AW-1:0]               f1_offset_ff, f1_offset_in;

   // The stage moves whenever the queue behind it has room.
   assign full   = link_full;
   assign accept = push && !link_full;

   // The first sample, the final sample and any index past the scan give no point.
   assign drop = (req_sample_index == '0) ||
                 (({1'b0, req_sample_index} + (IW+1)'(1)) >= {1'b0, scan_length});

   assign step_prod = (IW+AW)'(req_sample_index) * (IW+AW)'(angle_step);

   always_comb begin
      f1_valid_in  = f1_valid_ff;
      f1_range_in  = f1_range_ff;
      f1_index_in  = f1_index_ff;
      f1_last_in   = f1_last_ff;
      f1_offset_in = f1_offset_ff;
      if (!link_full) begin
         f1_valid_in  = accept && !drop;
         f1_range_in  = req_range_mm[spc_pkg::RANGE_W-1:0];
         f1_index_in  = req_sample_index;
         f1_last_in   = (({1'b0, req_sample_index} + (IW+1)'(2)) == {1'b0, scan_length});
         f1_offset_in = step_prod[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_range_ff  <= f1_range_in;
      f1_index_ff  <= f1_index_in;
      f1_last_ff   <= f1_last_in;
      f1_offset_ff <= f1_offset_in;
   end

   assign link_push              = f1_valid_ff && !link_full;
   assign link_item.range_mm     = f1_range_ff;
   assign link_item.sample_index = f1_index_ff;
   assign link_item.last_point   = f1_last_ff;
   assign link_item.angle        = (start_angle + f1_offset_ff) & spc_pkg::ANGLE_MASK;

endmodule
`default_nettype wire

// ===== design/spc_link_queue.sv =====
`default_nettype none
`include "scan_polar_to_cartesian_top_defines.svh"
module spc_link_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire spc_pkg::link_item_type push_item,
   output logic                        full,
   input  wire logic                   pop,
   output spc_pkg::link_item_type      pop_item,
   output logic                        empty
);

   localparam int PW = spc_pkg::LINK_PTR_W;
   localparam int NW = spc_pkg::LINK_CNT_W;

   spc_pkg::link_item_type entry_ff [0:spc_pkg::LINK_DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full     = (count_ff == NW'(spc_pkg::LINK_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + NW'(1);
         2'b01:   count_in = count_ff - NW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `SPC_ASSERT(a_link_no_overflow, push |-> !full)
   `SPC_ASSERT(a_link_no_underflow, pop |-> !empty)
   `SPC_ASSERT(a_link_count_up, (push && !pop) |=> (count_ff == $past(count_ff) + NW'(1)))

endmodule
`default_nettype wire

// ===== design/spc_back.sv =====
`default_nettype none
`include "scan_polar_to_cartesian_top_defines.svh"
module spc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              link_empty,
   input  wire spc_pkg::link_item_type            link_item,
   output logic                                   link_pop,
   input  wire logic                              pop,
   output logic                                   empty,
   output logic signed [spc_pkg::COORD_W-1:0]     rsp_x_mm,
   output logic signed [spc_pkg::COORD_W-1:0]     rsp_y_mm,
   output logic [spc_pkg::INDEX_W-1:0]            rsp_point_index,
   output logic                                   rsp_last_point
);

   localparam int STEPS = spc_pkg::CORDIC_STEPS;
   localparam int CW    = spc_pkg::CW;
   localparam int ZW    = spc_pkg::ZW;
   localparam int PRW   = spc_pkg::PROD_W;
   localparam int IW    = spc_pkg::INDEX_W;
   localparam int OW    = spc_pkg::COORD_W;
   localparam int RW    = spc_pkg::R_W;
   localparam int SW    = spc_pkg::RSAT_W;
   localparam int OPW   = spc_pkg::OUT_PTR_W;
   localparam int ONW   = spc_pkg::OUT_CNT_W;
   localparam int SHIFT = spc_pkg::PRESCALE_SHIFT;
   localparam int FRAC  = spc_pkg::FRAC;

   logic adv;
   logic out_full;
   logic out_push;

   // Stage A: quadrant split and range pre-scaling product.
   logic                 a_valid_ff, a_valid_in;
   logic [PRW-1:0]       a_prod_ff, a_prod_in;
   logic signed [ZW-1:0] a_z_ff, a_z_in;
   logic [1:0]           a_quad_ff, a_quad_in;
   logic [IW-1:0]        a_index_ff, a_index_in;
   logic                 a_last_ff, a_last_in;
   logic [ZW-1:0]        a_turned;

   // CORDIC stages: entry 0 holds the pre-scaled vector, entry i+1 the result of step i.
   logic                 cv_ff [0:STEPS];
   logic                 cv_in [0:STEPS];
   spc_pkg::cordic_type  cd_ff [0:STEPS];
   spc_pkg::cordic_type  cd_in [0:STEPS];
   logic [PRW:0]         x0_sum;

   // Result stages: quadrant restore, magnitude rounding, saturation.
   logic                 r1_valid_ff, r1_valid_in;
   logic signed [CW-1:0] r1_x_ff, r1_x_in, r1_y_ff, r1_y_in;
   logic [IW-1:0]        r1_index_ff, r1_index_in;
   logic                 r1_last_ff, r1_last_in;

   logic                 r2_valid_ff, r2_valid_in;
   logic [RW-1:0]        r2_xmag_ff, r2_xmag_in, r2_ymag_ff, r2_ymag_in;
   logic                 r2_xneg_ff, r2_xneg_in, r2_yneg_ff, r2_yneg_in;
   logic [IW-1:0]        r2_index_ff, r2_index_in;
   logic                 r2_last_ff, r2_last_in;
   logic [CW-1:0]        xmag, ymag;
   logic [CW:0]          xsum, ysum;

   logic                 r3_valid_ff, r3_valid_in;
   spc_pkg::point_type   r3_point_ff, r3_point_in;
   logic [SW-1:0]        xr_ext, yr_ext;
   logic [OW-2:0]        xsat, ysat;

   // Output queue.
   spc_pkg::point_type   out_entry_ff [0:spc_pkg::OUT_DEPTH-1];
   logic [OPW-1:0]       out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [ONW-1:0]       out_count_ff, out_count_in;
   logic                 out_pop;

   // The whole pipeline moves together while the output queue has room.
   assign out_full = (out_count_ff == ONW'(spc_pkg::OUT_DEPTH));
   assign adv      = !out_full;
   assign link_pop = adv && !link_empty;
   assign out_push = adv && r3_valid_ff;
   assign out_pop  = pop && !empty;

   // Stage A
   always_comb begin
      a_turned   = link_item.angle + ZW'(32'h20000000);
      a_valid_in = link_pop;
      a_quad_in  = a_turned[ZW-1:ZW-2];
      a_z_in     = $signed({2'b00, a_turned[ZW-3:0]}) - $signed(ZW'(32'h20000000));
      a_prod_in  = PRW'(link_item.range_mm) * PRW'(spc_pkg::KINV);
      a_index_in = link_item.sample_index;
      a_last_in  = link_item.last_point;
   end

   // CORDIC stages
   always_comb begin
      x0_sum                = {1'b0, a_prod_ff} + (PRW+1)'(1 << (SHIFT - 1));
      cv_in[0]              = a_valid_ff;
      cd_in[0].x            = $signed({2'b00, x0_sum[PRW-1:SHIFT]});
      cd_in[0].y            = '0;
      cd_in[0].z            = a_z_ff;
      cd_in[0].quadrant     = a_quad_ff;
      cd_in[0].sample_index = a_index_ff;
      cd_in[0].last_point   = a_last_ff;
      for (int i = 0; i < STEPS; i++) begin
         cv_in[i+1] = cv_ff[i];
         cd_in[i+1] = cd_ff[i];
         if (!cd_ff[i].z[ZW-1]) begin
            cd_in[i+1].x = cd_ff[i].x - (cd_ff[i].y >>> i);
            cd_in[i+1].y = cd_ff[i].y + (cd_ff[i].x >>> i);
            cd_in[i+1].z = cd_ff[i].z - $signed(spc_pkg::ATAN_TAB[i]);
         end else begin
            cd_in[i+1].x = cd_ff[i].x + (cd_ff[i].y >>> i);
            cd_in[i+1].y = cd_ff[i].y - (cd_ff[i].x >>> i);
            cd_in[i+1].z = cd_ff[i].z + $signed(spc_pkg::ATAN_TAB[i]);
         end
      end
   end

   // R1: put the rotated vector back into its quadrant.
   always_comb begin
      r1_valid_in = cv_ff[STEPS];
      r1_index_in = cd_ff[STEPS].sample_index;
      r1_last_in  = cd_ff[STEPS].last_point;
      unique case (cd_ff[STEPS].quadrant)
         2'd0: begin
            r1_x_in = cd_ff[STEPS].x;
            r1_y_in = cd_ff[STEPS].y;
         end
         2'd1: begin
            r1_x_in = -cd_ff[STEPS].y;
            r1_y_in = cd_ff[STEPS].x;
         end
         2'd2: begin
            r1_x_in = -cd_ff[STEPS].x;
            r1_y_in = -cd_ff[STEPS].y;
         end
         default: begin
            r1_x_in = cd_ff[STEPS].y;
            r1_y_in = -cd_ff[STEPS].x;
         end
      endcase
   end

   // R2: round the magnitude half away from zero.
   always_comb begin
      r2_valid_in = r1_valid_ff;
      r2_index_in = r1_index_ff;
      r2_last_in  = r1_last_ff;
      r2_xneg_in  = r1_x_ff[CW-1];
      r2_yneg_in  = r1_y_ff[CW-1];
      xmag        = r1_x_ff[CW-1] ? CW'(-r1_x_ff) : CW'(r1_x_ff);
      ymag        = r1_y_ff[CW-1] ? CW'(-r1_y_ff) : CW'(r1_y_ff);
      xsum        = {1'b0, xmag} + (CW+1)'(1 << (FRAC - 1));
      ysum        = {1'b0, ymag} + (CW+1)'(1 << (FRAC - 1));
      r2_xmag_in  = xsum[CW:FRAC];
      r2_ymag_in  = ysum[CW:FRAC];
   end

   // R3: saturate and restore the sign.
   always_comb begin
      r3_valid_in = r2_valid_ff;
      xr_ext      = SW'(r2_xmag_ff);
      yr_ext      = SW'(r2_ymag_ff);
      xsat        = (xr_ext > SW'(spc_pkg::COORD_MAX)) ? (OW-1)'(spc_pkg::COORD_MAX)
                                                        : xr_ext[OW-2:0];
      ysat        = (yr_ext > SW'(spc_pkg::COORD_MAX)) ? (OW-1)'(spc_pkg::COORD_MAX)
                                                        : yr_ext[OW-2:0];
      r3_point_in.x_mm        = r2_xneg_ff ? -$signed({1'b0, xsat}) : $signed({1'b0, xsat});
      r3_point_in.y_mm        = r2_yneg_ff ? -$signed({1'b0, ysat}) : $signed({1'b0, ysat});
      r3_point_in.point_index = r2_index_ff;
      r3_point_in.last_point  = r2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
         r3_valid_ff <= 1'b0;
         for (int i = 0; i <= STEPS; i++) begin
            cv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         a_valid_ff  <= a_valid_in;
         r1_valid_ff <= r1_valid_in;
         r2_valid_ff <= r2_valid_in;
         r3_valid_ff <= r3_valid_in;
         for (int i = 0; i <= STEPS; i++) begin
            cv_ff[i] <= cv_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff   <= a_prod_in;
         a_z_ff      <= a_z_in;
         a_quad_ff   <= a_quad_in;
         a_index_ff  <= a_index_in;
         a_last_ff   <= a_last_in;
         for (int i = 0; i <= STEPS; i++) begin
            cd_ff[i] <= cd_in[i];
         end
         r1_x_ff     <= r1_x_in;
         r1_y_ff     <= r1_y_in;
         r1_index_ff <= r1_index_in;
         r1_last_ff  <= r1_last_in;
         r2_xmag_ff  <= r2_xmag_in;
         r2_ymag_ff  <= r2_ymag_in;
         r2_xneg_ff  <= r2_xneg_in;
         r2_yneg_ff  <= r2_yneg_in;
         r2_index_ff <= r2_index_in;
         r2_last_ff  <= r2_last_in;
         r3_point_ff <= r3_point_in;
      end
   end

   // Output queue
   always_comb begin
      out_wr_in = out_push ? out_wr_ff + OPW'(1) : out_wr_ff;
      out_rd_in = out_pop  ? out_rd_ff + OPW'(1) : out_rd_ff;
      unique case ({out_push, out_pop})
         2'b10:   out_count_in = out_count_ff + ONW'(1);
         2'b01:   out_count_in = out_count_ff - ONW'(1);
         default: out_count_in = out_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_entry_ff[out_wr_ff] <= r3_point_ff;
      end
   end

   assign empty           = (out_count_ff == '0);
   assign rsp_x_mm        = out_entry_ff[out_rd_ff].x_mm;
   assign rsp_y_mm        = out_entry_ff[out_rd_ff].y_mm;
   assign rsp_point_index = out_entry_ff[out_rd_ff].point_index;
   assign rsp_last_point  = out_entry_ff[out_rd_ff].last_point;

   `SPC_ASSERT_ALWAYS(a_out_reset_clears, reset |=> (out_count_ff == '0))
   `SPC_ASSERT(a_out_count_bound, out_count_ff <= ONW'(spc_pkg::OUT_DEPTH))
   `SPC_ASSERT(a_stall_keeps_result, (!adv && r3_valid_ff) |=> r3_valid_ff)
   `SPC_ASSERT(a_out_count_down, (out_pop && !out_push) |=> (out_count_ff == $past(out_count_ff) - ONW'(1)))

endmodule
`default_nettype wire

// ===== design/scan_polar_to_cartesian_top.sv =====
`default_nettype none
// Laser-scan polar to cartesian converter. Each request carries one range sample in
// millimeters and its index within the scan; the beam angle is start_angle plus the index
// times angle_step, a 32-bit binary angle where a full turn is 2^32. The block returns
// x = range * cos(angle) and y = range * sin(angle), rounded half away from zero to whole
// millimeters and saturated to +/-65535, together with the sample index and a flag that
// marks the point of index scan_length - 2 as the last of the scan. Samples at index zero
// and at index scan_length - 1 or above give no point, so a scan of fewer than three
// samples gives none at all. The block takes one request per clock cycle for as long as
// results are popped. On its way to a point, a request passes the front-end register, the
// link queue, the pre-scaling multiply, the register that loads the rotation pipeline,
// 30 CORDIC steps, three result stages (quadrant, rounding, saturation) and the
// result queue. Full rises only when the four-entry link queue between the front end and
// the rotation pipeline is full, which happens once the four-entry result queue has filled
// and the pipeline has stopped. Configuration registers are written through the
// valid/ready port, which is always ready; write them only while no request is in flight.
module scan_polar_to_cartesian_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request side.
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic [spc_pkg::RANGE_IN_W-1:0]        req_range_mm,
   input  wire logic [spc_pkg::INDEX_W-1:0]           req_sample_index,
   // Result side.
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic signed [spc_pkg::COORD_W-1:0]         rsp_x_mm,
   output logic signed [spc_pkg::COORD_W-1:0]         rsp_y_mm,
   output logic [spc_pkg::INDEX_W-1:0]                rsp_point_index,
   output logic                                       rsp_last_point,
   // Configuration port.
   input  wire logic                                  valid,
   output logic                                       ready,
   input  wire logic [spc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [spc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [spc_pkg::ANGLE_W-1:0] start_angle_ff, start_angle_in;
   logic [spc_pkg::ANGLE_W-1:0] angle_step_ff, angle_step_in;
   logic [spc_pkg::INDEX_W-1:0] scan_length_ff, scan_length_in;

   // Link between front end and rotation pipeline.
   logic                   link_push;
   logic                   link_full;
   logic                   link_pop;
   logic                   link_empty;
   spc_pkg::link_item_type link_push_item;
   spc_pkg::link_item_type link_pop_item;

   // The register port never stalls. A write to an index beyond the map is dropped.
   assign ready = 1'b1;

   always_comb begin
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      scan_length_in = scan_length_ff;
      if (valid && ready) begin
         unique case (csr_index)
            spc_pkg::CSR_START_ANGLE: start_angle_in = csr_wdata[spc_pkg::ANGLE_W-1:0];
            spc_pkg::CSR_ANGLE_STEP:  angle_step_in  = csr_wdata[spc_pkg::ANGLE_W-1:0];
            spc_pkg::CSR_SCAN_LENGTH: scan_length_in = csr_wdata[spc_pkg::INDEX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= spc_pkg::START_ANGLE_RESET;
         angle_step_ff  <= spc_pkg::ANGLE_STEP_RESET;
         scan_length_ff <= spc_pkg::SCAN_LENGTH_RESET;
      end else begin
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
         scan_length_ff <= scan_length_in;
      end
   end

   // The front end filters out samples that give no point and forms the beam angle.
   spc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_range_mm     (req_range_mm),
      .req_sample_index (req_sample_index),
      .start_angle      (start_angle_ff),
      .angle_step       (angle_step_ff),
      .scan_length      (scan_length_ff),
      .link_full        (link_full),
      .link_push        (link_push),
      .link_item        (link_push_item)
   );

   // The short queue lets the front end keep accepting while the pipeline is stalled.
   spc_link_queue u_link_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (link_push),
      .push_item (link_push_item),
      .full      (link_full),
      .pop       (link_pop),
      .pop_item  (link_pop_item),
      .empty     (link_empty)
   );

   // The back end rotates the pre-scaled range vector and rounds the coordinates.
   spc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .link_empty      (link_empty),
      .link_item       (link_pop_item),
      .link_pop        (link_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_x_mm        (rsp_x_mm),
      .rsp_y_mm        (rsp_y_mm),
      .rsp_point_index (rsp_point_index),
      .rsp_last_point  (rsp_last_point)
   );

endmodule
`default_nettype wire

// ===== sim/scan_polar_to_cartesian_top_tb.sv =====
`timescale 1ns / 100ps

module scan_polar_to_cartesian_top_tb;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 12;
   // Long enough to cover the way from request to point, with margin on top of that.
   localparam int SETTLE_CYCLES = 60;
   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 4000;

   // Fixed-point constants of the rotation: 30 steps, range pre-scaled by 2^30 / gain,
   // 16 fraction bits in the rotated coordinates.
   localparam int ROTATION_STEPS = 30;
   localparam longint PRESCALE_GAIN = 64'sd652032874;
   localparam int PRESCALE_SHIFT = 14;
   localparam int FRACTION_BITS = 16;
   localparam longint COORD_LIMIT = 64'sd65535;
   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

   // Index that no register answers to; writes to it must leave every register alone.
   localparam logic [spc_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   // atan(2^-i) in binary-angle units, a full turn being 2^32.
   localparam logic [31:0] ARCTAN_STEPS [0:ROTATION_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Every input of the block starts at a known value.
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 push = 1'b0;
   logic                                 full;
   logic [spc_pkg::RANGE_IN_W-1:0]       req_range_mm = '0;
   logic [spc_pkg::INDEX_W-1:0]          req_sample_index = '0;
   logic                                 empty;
   logic                                 pop = 1'b0;
   logic signed [spc_pkg::COORD_W-1:0]   rsp_x_mm;
   logic signed [spc_pkg::COORD_W-1:0]   rsp_y_mm;
   logic [spc_pkg::INDEX_W-1:0]          rsp_point_index;
   logic                                 rsp_last_point;
   logic                                 valid = 1'b0;
   logic                                 ready;
   logic [spc_pkg::CSR_INDEX_W-1:0]      csr_index = '0;
   logic [spc_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   // The testbench's own copy of the scan geometry, updated on every register write.
   logic [spc_pkg::ANGLE_W-1:0]          start_angle_q = spc_pkg::START_ANGLE_RESET;
   logic [spc_pkg::ANGLE_W-1:0]          angle_step_q = spc_pkg::ANGLE_STEP_RESET;
   logic [spc_pkg::INDEX_W-1:0]          scan_length_q = spc_pkg::SCAN_LENGTH_RESET;

   // Points predicted for accepted requests, oldest first.
   spc_pkg::point_type                   pending_points[$];
   int                                   error_count = 0;
   int                                   stall_cycles = 0;
   // Percent of cycles in which the sender idles and the receiver stalls.
   int                                   idle_pct = 0;
   int                                   stall_pct = 0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   scan_polar_to_cartesian_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_range_mm     (req_range_mm),
      .req_sample_index (req_sample_index),
      .empty            (empty),
      .pop              (pop),
      .rsp_x_mm         (rsp_x_mm),
      .rsp_y_mm         (rsp_y_mm),
      .rsp_point_index  (rsp_point_index),
      .rsp_last_point   (rsp_last_point),
      .valid            (valid),
      .ready            (ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Rounds a coordinate with 16 fraction bits to whole millimeters, half away from zero,
   // and clamps the magnitude to what the 17-bit result field can carry.
   function automatic logic [spc_pkg::COORD_W-1:0] round_to_mm(input longint fixed_val);
      longint magnitude;
      longint whole;
      magnitude = (fixed_val < 0) ? -fixed_val : fixed_val;
      whole = (magnitude + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      if (whole > COORD_LIMIT) begin
         whole = COORD_LIMIT;
      end
      if (fixed_val < 0) begin
         whole = -whole;
      end
      return whole[spc_pkg::COORD_W-1:0];
   endfunction

   // Works out the point that one request should give under the current register values.
   // Returns zero when the sample is the first of a scan or lies at or past its final one.
   function automatic bit predict_point(input logic [spc_pkg::INDEX_W-1:0] range_in,
                                        input logic [spc_pkg::INDEX_W-1:0] index_in,
                                        output spc_pkg::point_type point);
      logic [31:0] beam;
      logic [31:0] turned;
      logic [1:0]  quadrant;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      longint      x_out;
      longint      y_out;
      int          step_i;
      point = '0;
      if (index_in == '0 || {1'b0, index_in} + 17'd1 >= {1'b0, scan_length_q}) begin
         return 1'b0;
      end
      // The beam angle wraps modulo a full turn, and only its top ANGLE_BITS bits count.
      beam = start_angle_q + 32'(index_in) * angle_step_q;
      beam = (beam >> (32 - spc_pkg::ANGLE_BITS)) << (32 - spc_pkg::ANGLE_BITS);
      // Shifting by an eighth turn centers each quadrant on its residual range.
      turned = beam + EIGHTH_TURN;
      quadrant = turned[31:30];
      z = longint'({2'b00, turned[29:0]}) - longint'(EIGHTH_TURN);
      x = ((longint'(range_in) & ((64'sd1 <<< spc_pkg::RANGE_BITS) - 1)) * PRESCALE_GAIN
           + (64'sd1 <<< (PRESCALE_SHIFT - 1))) >>> PRESCALE_SHIFT;
      y = 0;
      for (step_i = 0; step_i < ROTATION_STEPS; step_i++) begin
         dx = y >>> step_i;
         dy = x >>> step_i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ARCTAN_STEPS[step_i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ARCTAN_STEPS[step_i]);
         end
      end
      case (quadrant)
         2'd0: begin
            x_out = x;
            y_out = y;
         end
         2'd1: begin
            x_out = -y;
            y_out = x;
         end
         2'd2: begin
            x_out = -x;
            y_out = -y;
         end
         default: begin
            x_out = y;
            y_out = -x;
         end
      endcase
      point.x_mm = round_to_mm(x_out);
      point.y_mm = round_to_mm(y_out);
      point.point_index = index_in;
      point.last_point = ({1'b0, index_in} + 17'd2 == {1'b0, scan_length_q});
      return 1'b1;
   endfunction

   // Angles for the random phases lean on the extremes of the 32-bit range.
   function automatic logic [31:0] pick_angle();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         return 32'h0000_0000;
      end else if (roll < 30) begin
         return 32'hFFFF_FFFF;
      end
      return $urandom;
   endfunction

   // Sends one request. The sender may idle first; push stays high across back-to-back
   // requests, and the request is taken at the first edge where full is low.
   task automatic send_sample(input logic [spc_pkg::INDEX_W-1:0] range_in,
                              input logic [spc_pkg::INDEX_W-1:0] index_in);
      spc_pkg::point_type expected_point;
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_range_mm <= range_in;
      req_sample_index <= index_in;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      if (predict_point(range_in, index_in, expected_point)) begin
         pending_points = {pending_points, expected_point};
      end
   endtask

   // Stops sending and waits until every predicted point has been popped. Always takes at
   // least one edge so that push is never lowered and raised in the same time step.
   task automatic drain_points();
      push <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_points.size() != 0);
   endtask

   // Requests that give no point may still be inside the pipeline after the last point has
   // come out, so register writes wait out the full latency as well.
   task automatic settle_pipeline();
      drain_points();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register. Valid stays high when another write follows directly.
   task automatic write_register(input logic [spc_pkg::CSR_INDEX_W-1:0] index_in,
                                 input logic [spc_pkg::CSR_DATA_W-1:0] data,
                                 input bit more_follow);
      valid <= 1'b1;
      csr_index <= index_in;
      csr_wdata <= data;
      @(posedge clock);
      while (!ready) begin
         @(posedge clock);
      end
      if (!more_follow) begin
         valid <= 1'b0;
      end
      case (index_in)
         spc_pkg::CSR_START_ANGLE: start_angle_q = data;
         spc_pkg::CSR_ANGLE_STEP:  angle_step_q = data;
         spc_pkg::CSR_SCAN_LENGTH: scan_length_q = data[spc_pkg::INDEX_W-1:0];
         default: ;
      endcase
   endtask

   // The scan length is passed as a full data word so that its upper bits, which the
   // register drops, can be exercised too.
   task automatic configure_scan(input logic [31:0] start_angle, input logic [31:0] angle_step,
                                 input logic [spc_pkg::CSR_DATA_W-1:0] length_word);
      write_register(spc_pkg::CSR_START_ANGLE, start_angle, 1'b1);
      write_register(spc_pkg::CSR_ANGLE_STEP, angle_step, 1'b1);
      write_register(spc_pkg::CSR_SCAN_LENGTH, length_word, 1'b0);
   endtask

   // Reset values: one degree per sample over a 360-sample scan. Covers the axis directions at
   // 90, 180 and 270 degrees, the first and final samples, an index far past the scan, the last
   // point flag, and the range extremes with alternating bit patterns.
   task automatic test_reset_geometry();
      send_sample(16'd1000, 16'd0);
      send_sample(16'hFFFF, 16'd1);
      send_sample(16'hFFFF, 16'd90);
      send_sample(16'hFFFF, 16'd180);
      send_sample(16'hFFFF, 16'd270);
      send_sample(16'd0, 16'd45);
      send_sample(16'd1, 16'd358);
      send_sample(16'd500, 16'd359);
      send_sample(16'd500, 16'hFFFF);
      send_sample(16'hAAAA, 16'd1);
      send_sample(16'h5555, 16'd2);
   endtask

   // Register extremes: the longest scan with the largest step, then a three-sample scan
   // written with junk in the upper data bits, then a write to an unmapped index that must
   // not disturb anything.
   task automatic test_register_extremes();
      settle_pipeline();
      configure_scan(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF);
      send_sample(16'hFFFF, 16'd65533);
      send_sample(16'hFFFF, 16'd65534);
      send_sample(16'h8000, 16'h8000);
      settle_pipeline();
      configure_scan(32'hFFFF_FFFF, 32'h0000_0000, 32'hABCD_0003);
      send_sample(16'hFFFF, 16'd1);
      send_sample(16'd1, 16'd2);
      settle_pipeline();
      write_register(CSR_UNMAPPED, 32'h0000_0000, 1'b0);
      send_sample(16'd1234, 16'd1);
   endtask

   // Scans of zero, one and two samples never give a point.
   task automatic test_short_scans();
      int length_i;
      for (length_i = 0; length_i < 3; length_i++) begin
         settle_pipeline();
         configure_scan(32'h4000_0000, spc_pkg::ANGLE_STEP_RESET, 32'(length_i));
         send_sample(16'd777, 16'd0);
         send_sample(16'd777, 16'd1);
      end
   endtask

   // Random traffic under one idling profile and one random scan geometry. Most requests
   // fall inside the scan; a few hit its last point, the first sample, or lie at or past the final one.
   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int points_wanted);
      int                          length_i;
      int                          points_sent;
      int                          roll;
      logic [spc_pkg::INDEX_W-1:0] index_val;
      logic [spc_pkg::INDEX_W-1:0] range_val;
      logic [spc_pkg::INDEX_W-1:0] length_val;
      settle_pipeline();
      roll = $urandom_range(99);
      if (roll < 25) begin
         length_val = 16'hFFFF;
      end else if (roll < 50) begin
         length_val = 16'($urandom_range(10, 3));
      end else begin
         length_val = 16'($urandom_range(65535, 3));
      end
      configure_scan(pick_angle(), pick_angle(), {16'($urandom), length_val});
      length_i = int'(scan_length_q);
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      points_sent = 0;
      while (points_sent < points_wanted) begin
         roll = $urandom_range(99);
         if (roll < 84) begin
            index_val = 16'($urandom_range(length_i - 2, 1));
         end else if (roll < 90) begin
            index_val = 16'(length_i - 2);
         end else if (roll < 95) begin
            index_val = '0;
         end else begin
            index_val = 16'($urandom_range(65535, length_i - 1));
         end
         roll = $urandom_range(99);
         if (roll < 80) begin
            range_val = 16'($urandom);
         end else if (roll < 90) begin
            range_val = 16'($urandom_range(15));
         end else begin
            range_val = 16'hFFFF - 16'($urandom_range(3));
         end
         if (index_val != '0 && int'(index_val) + 1 < length_i) begin
            points_sent++;
         end
         // Now and then the sender holds off until every predicted point has been popped.
         if ($urandom_range(199) == 0) begin
            drain_points();
         end
         send_sample(range_val, index_val);
      end
      drain_points();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   // The receiver pops at random according to the current stall profile.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Every popped point is compared field by field with the oldest prediction.
   always @(posedge clock) begin
      spc_pkg::point_type expected_point;
      if (!reset && pop && !empty) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point: index %0d x %0d y %0d last %0b", $time,
                     rsp_point_index, rsp_x_mm, rsp_y_mm, rsp_last_point);
            error_count++;
         end else begin
            expected_point = pending_points.pop_front();
            if (rsp_x_mm !== expected_point.x_mm) begin
               $display("%0t: x_mm mismatch: expected %0d, actual %0d", $time,
                        expected_point.x_mm, rsp_x_mm);
               error_count++;
            end
            if (rsp_y_mm !== expected_point.y_mm) begin
               $display("%0t: y_mm mismatch: expected %0d, actual %0d", $time,
                        expected_point.y_mm, rsp_y_mm);
               error_count++;
            end
            if (rsp_point_index !== expected_point.point_index) begin
               $display("%0t: point_index mismatch: expected %0d, actual %0d", $time,
                        expected_point.point_index, rsp_point_index);
               error_count++;
            end
            if (rsp_last_point !== expected_point.last_point) begin
               $display("%0t: last_point mismatch: expected %0b, actual %0b", $time,
                        expected_point.last_point, rsp_last_point);
               error_count++;
            end
         end
      end
   end

   // Hang detection: any handshake on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (valid && ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_register_extremes();
      test_short_scans();
      test_random_traffic(0, 0, 235);
      test_random_traffic(63, 0, 235);
      test_random_traffic(0, 63, 235);
      test_random_traffic(30, 30, 235);
      settle_pipeline();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/spc_pkg.sv
design/spc_front.sv
design/spc_link_queue.sv
design/spc_back.sv
design/scan_polar_to_cartesian_top.sv
sim/scan_polar_to_cartesian_top_tb.sv
